// ===== rtl/core/ilid_pkg.sv =====
// Shared types and constants for the indexed list with insert and delete.
`default_nettype none

package ilid_pkg;

    // Fixed widths of the command and result fields.
    localparam int OP_W    = 2;
    localparam int POS_W   = 9;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 9;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UP   = 6'b000010,
        S_PUT  = 6'b000100,
        S_DEL0 = 6'b001000,
        S_DN   = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    // Read of a single element waits in the same state as the first delete read.
    localparam state_t S_RDW = S_DEL0;

endpackage

`default_nettype wire

// ===== rtl/core/indexed_list_insert_delete.sv =====
// Append, insert at the end and any refused command go from idle straight to the hand-over
// state; a read first passes the first-read state, an insert shifts up and then puts the
// value, a delete reads the element and shifts the rest down. One command at a time; a shift
// moves one element a cycle through the store's single read and write port.
// A new command is taken while the previous result still waits in the output register.
// Reset clears the count, the sequencer and the output valid, and sets the limit to 256.
`default_nettype none

module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [VAL_W-1:0]  value,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      status,
    output logic [VAL_W-1:0]       data,
    output logic [CNT_W-1:0]       count,
    // capacity limit write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  cfg_data
);

    localparam int AW = $clog2(DEPTH);

    // The limit register can never exceed its own range, so a store deeper than
    // that is only ever used up to the largest limit.
    localparam int CNT_MAX    = (1 << CNT_W) - 1;
    localparam int DEPTH_CLIP = (DEPTH > CNT_MAX) ? (CNT_MAX + 1) : DEPTH;
    localparam logic [CNT_W:0] DEPTH_CAP = (CNT_W + 1)'(DEPTH_CLIP);

    // Control state.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    cap_reg;
    logic                out_valid_reg, out_valid_next;

    // Working payload.
    logic [AW-1:0]         pos_reg, pos_next;
    logic [ELEM_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    status_t               res_status_reg, res_status_next;
    logic [VAL_W-1:0]      res_data_reg, res_data_next;
    logic [STAT_W-1:0]     out_status_reg;
    logic [VAL_W-1:0]      out_data_reg;
    logic [CNT_W-1:0]      out_count_reg;

    // The opcode is held for the shared first-read step, where a delete and a read differ.
    logic [OP_W-1:0]       opcode_held_reg;

    // Store port.
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [ELEM_WIDTH-1:0] mem_rdata;

    logic accept;
    logic full;
    logic out_free;
    logic out_load;
    op_t  op;

    ilid_store #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign op        = op_t'(opcode);

    // The list is full at the programmed limit, or at the store depth if that is lower.
    assign full = (count_reg >= cap_reg) || ({1'b0, count_reg} >= DEPTH_CAP);

    // The output register may be reloaded when it is empty or being taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    // The sequencer. Shifts overlap a read of one entry with the write of the entry read
    // in the previous cycle; the read always runs ahead of the writes in the direction of
    // travel, so no entry is read in the same cycle as it is written and no forwarding is
    // needed. Each command ends before the next is taken, which keeps commands apart.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        rd_ptr_next     = rd_ptr_reg;
        rem_next        = rem_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next        = AW'(position);
                    val_next        = ELEM_WIDTH'(value);
                    res_status_next = ST_OK;
                    res_data_next   = '0;
                    state_next      = S_RESP;
                    unique case (op)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = ELEM_WIDTH'(value);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            priority if (position > count_reg)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (position == count_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = ELEM_WIDTH'(value);
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // Start from the last element and move downwards.
                                mem_raddr   = AW'(count_reg - CNT_W'(1));
                                rd_ptr_next = AW'(count_reg - CNT_W'(1));
                                rem_next    = count_reg - position;
                                state_next  = S_UP;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (position >= count_reg)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_raddr   = AW'(position);
                                rd_ptr_next = AW'(position);
                                rem_next    = count_reg - position - CNT_W'(1);
                                state_next  = S_DEL0;
                            end
                        end
                        OP_READ:
                        begin
                            if (position >= count_reg)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_raddr = AW'(position);
                                // A read has nothing to move, so it leaves the first
                                // delete step with no element left to shift.
                                rem_next   = '0;
                                state_next = S_RDW;
                            end
                        end
                    endcase
                end
            end

            S_UP:
            begin
                mem_we      = 1'b1;
                mem_waddr   = rd_ptr_reg + AW'(1);
                mem_wdata   = mem_rdata;
                mem_raddr   = rd_ptr_reg - AW'(1);
                rd_ptr_next = rd_ptr_reg - AW'(1);
                rem_next    = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            S_DEL0:
            begin
                // First read of a delete or a plain read: the element to return.
                res_data_next = VAL_W'(mem_rdata);
                if (rem_reg == '0)
                begin
                    if (op_t'(opcode_held_reg) == OP_DELETE)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr   = rd_ptr_reg + AW'(1);
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                    state_next  = S_DN;
                end
            end

            S_DN:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_ptr_reg - AW'(1);
                mem_wdata = mem_rdata;
                rem_next  = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr   = rd_ptr_reg + AW'(1);
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(256);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        rd_ptr_reg     <= rd_ptr_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        if (accept)
        begin
            opcode_held_reg <= opcode;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign count     = out_count_reg;

    // The count never passes the usable depth of the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} <= DEPTH_CAP))
        else $error("element count beyond usable store depth");

    // The count moves by at most one element per command.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_W'(1)) ||
             (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("element count jumped");

    // An accepted command always takes the sequencer out of the idle state.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("command accepted without the sequencer leaving idle");

    // A result appears only when the sequencer hands it over.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the hand-over step");

    // The store is never written while the sequencer waits to hand over a result.
    a_no_write_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) |-> !mem_we)
        else $error("store written during result hand-over");

endmodule

`default_nettype wire

// ===== rtl/core/ilid_store.sv =====
// Element store: one write port and one registered read port.
`default_nettype none

module ilid_store #(
    parameter int DEPTH      = 256,
    parameter int ELEM_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [ELEM_WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [ELEM_WIDTH-1:0] rd_data
);

    logic [ELEM_WIDTH-1:0] mem [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the indexed list with insert, delete, append and read.
module tb_top;
    import ilid_pkg::*;

    // Store size of the block as built, and how long the result side holds off
    // when it is asked to apply back-pressure for a long stretch.
    localparam int DEPTH       = 256;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 300;

    // One result beat as the block presents it.
    typedef struct packed {
        status_t     st;
        logic [31:0] dat;
        logic [8:0]  cnt;
    } list_result_t;

    // A line of the directed script is either a command beat or a write of the
    // capacity limit (the limit then travels in the val field).
    typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        op_t         op;
        logic [8:0]  pos;
        logic [31:0] val;
        bit          pinned;
        status_t     st;
        logic [31:0] dat;
        logic [8:0]  cnt;
    } row_t;

    // Directed script. Where the outcome is obvious (empty list, out of range
    // positions, a full list) the expected result is written into the row and
    // is pinned; every other row is checked against the list predictor.
    row_t dir_script [0:25] = '{
        // Empty list straight after reset: read, delete and insert past the end are refused.
        '{ROW_CMD, OP_READ,   9'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 9'd0},
        '{ROW_CMD, OP_DELETE, 9'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 9'd0},
        '{ROW_CMD, OP_INSERT, 9'd1,   32'hDEAD_BEEF, 1'b1, ST_RANGE, 32'h0, 9'd0},
        // Build a short list from both ends and the middle.
        '{ROW_CMD, OP_APPEND, 9'd0,   32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0, 9'd1},
        '{ROW_CMD, OP_APPEND, 9'd0,   32'h0000_0000, 1'b1, ST_OK,    32'h0, 9'd2},
        '{ROW_CMD, OP_INSERT, 9'd0,   32'hA5A5_5A5A, 1'b1, ST_OK,    32'h0, 9'd3},
        '{ROW_CMD, OP_INSERT, 9'd3,   32'h1234_5678, 1'b1, ST_OK,    32'h0, 9'd4},
        '{ROW_CMD, OP_INSERT, 9'd2,   32'h8000_0001, 1'b0, ST_OK,    32'h0, 9'd0},
        '{ROW_CMD, OP_READ,   9'd0,   32'h0000_0000, 1'b1, ST_OK,    32'hA5A5_5A5A, 9'd5},
        '{ROW_CMD, OP_READ,   9'd4,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 9'd0},
        // Positions at and beyond the count, up to the largest the field holds.
        '{ROW_CMD, OP_READ,   9'd5,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 9'd5},
        '{ROW_CMD, OP_READ,   9'd511, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 9'd5},
        '{ROW_CMD, OP_DELETE, 9'd511, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 9'd5},
        '{ROW_CMD, OP_INSERT, 9'd511, 32'h5A5A_A5A5, 1'b1, ST_RANGE, 32'h0, 9'd5},
        // Delete the last and the first element; append ignores its position.
        '{ROW_CMD, OP_DELETE, 9'd4,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 9'd0},
        '{ROW_CMD, OP_DELETE, 9'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 9'd0},
        '{ROW_CMD, OP_APPEND, 9'd511, 32'h5555_AAAA, 1'b0, ST_OK,    32'h0, 9'd0},
        // Limit lowered under the count: growth is refused, the range check on
        // insert still comes first, and reads reach every element held.
        '{ROW_CFG, OP_APPEND, 9'd0,   32'd1,         1'b0, ST_OK,    32'h0, 9'd0},
        '{ROW_CMD, OP_APPEND, 9'd0,   32'h1111_1111, 1'b1, ST_FULL,  32'h0, 9'd4},
        '{ROW_CMD, OP_INSERT, 9'd5,   32'h2222_2222, 1'b1, ST_RANGE, 32'h0, 9'd4},
        '{ROW_CMD, OP_INSERT, 9'd0,   32'h3333_3333, 1'b1, ST_FULL,  32'h0, 9'd4},
        '{ROW_CMD, OP_READ,   9'd3,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 9'd0},
        // A limit of zero: the list is always full, deletes still work.
        '{ROW_CFG, OP_APPEND, 9'd0,   32'd0,         1'b0, ST_OK,    32'h0, 9'd0},
        '{ROW_CMD, OP_DELETE, 9'd0,   32'h0000_0000, 1'b0, ST_OK,    32'h0, 9'd0},
        '{ROW_CMD, OP_APPEND, 9'd0,   32'h4444_4444, 1'b1, ST_FULL,  32'h0, 9'd3},
        '{ROW_CMD, OP_INSERT, 9'd3,   32'h6666_6666, 1'b1, ST_FULL,  32'h0, 9'd3}
    };

    // Random phases: the limit written at the start of each, how many command
    // beats it runs, and how strongly it favours growing the list (percent).
    // Most phases keep the list short so that shifts stay cheap; one phase
    // fills the whole store and the next drains it again.
    localparam int NUM_PHASES     = 10;
    localparam int PRESSURE_PHASE = 4;
    localparam int PH_LIMIT [NUM_PHASES] = '{511, 5, 1, 2, 24, 0, 12, 256, 7, 3};
    localparam int PH_ITEMS [NUM_PHASES] = '{140, 140, 120, 120, 160, 80, 150, 300, 380, 120};
    localparam int PH_GROW  [NUM_PHASES] = '{60, 55, 55, 55, 65, 50, 50, 95, 3, 55};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [8:0]  position;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] data;
    logic [8:0]  count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    // Pinned expectation travelling alongside the command beat. It is driven
    // exactly like the payload, so it is stable at the edge that accepts it.
    bit           pin_valid;
    list_result_t pin_exp;

    // Predictor state: its own copy of the store, the count and the limit.
    logic [31:0] list_mem [0:DEPTH-1];
    int          list_len;
    logic [8:0]  cap_limit;

    list_result_t pending_results [$];
    int           cmds_sent;
    int           results_seen;
    int           fail_count;

    // Back-pressure controls shared by the two sides of the bench.
    bit calm;
    int hold_req;
    int hold_done;

    indexed_list_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .count     (count),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // One line per mismatch, and a count of them.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // Applies one command to the predicted list and returns the result beat
    // the block must produce for it. The position check on insert comes before
    // the full check; a limit above the store size behaves as the store size.
    function automatic list_result_t list_apply(op_t op, logic [8:0] pos, logic [31:0] val);
        list_result_t r;
        int           k;
        int           lim;
        bit           full;
        r.st  = ST_OK;
        r.dat = '0;
        lim   = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
        full  = (list_len >= lim);
        case (op)
            OP_APPEND:
            begin
                if (full)
                    r.st = ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                if (pos > list_len)
                    r.st = ST_RANGE;
                else if (full)
                    r.st = ST_FULL;
                else
                begin
                    for (k = list_len; k > pos; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (pos >= list_len)
                    r.st = ST_RANGE;
                else
                begin
                    r.dat = list_mem[pos];
                    for (k = pos; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            default:
            begin
                if (pos >= list_len)
                    r.st = ST_RANGE;
                else
                    r.dat = list_mem[pos];
            end
        endcase
        r.cnt = list_len[8:0];
        return r;
    endfunction

    // Idle lengths: mostly none or a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Everything is sampled at the rising edge, before any of this edge's
    // nonblocking updates land, so each handshake is seen exactly as the block
    // saw it. Results are checked before the new command is predicted so that
    // a stray result can never be matched against a command of the same edge.
    always @(posedge clk)
    begin : list_scoreboard
        list_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing pending", {status, data[29:0]}, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (data !== want.dat)
                        report_mismatch("data", data, want.dat);
                    if (count !== want.cnt)
                        report_mismatch("count", 32'(count), 32'(want.cnt));
                end
            end
            if (cfg_valid && cfg_ready)
                cap_limit = cfg_data;
            if (in_valid && !in_stall)
            begin
                want = list_apply(op_t'(opcode), position, value);
                if (pin_valid)
                    want = pin_exp;
                pending_results.push_back(want);
            end
        end
    end

    // Result side. A request for a long hold-off is served in full here, with
    // the cycles counted in this process; otherwise short and occasional long
    // stalls alternate with runs of free cycles.
    initial
    begin : result_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                hold_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    run_left = $urandom_range(0, 12);
                    if (!calm)
                        stall_left = pick_gap();
                end
            end
        end
    end

    // Presents one command beat and holds it, payload unchanged, until the
    // block takes it. Valid is left high so that a following beat is offered
    // straight away.
    task automatic drive_beat(op_t op, logic [8:0] pos, logic [31:0] val,
                              bit pinned, list_result_t exp_res);
        in_valid  <= 1'b1;
        opcode    <= op;
        position  <= pos;
        value     <= val;
        pin_valid <= pinned;
        pin_exp   <= exp_res;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        cmds_sent++;
    endtask

    // Optional idle gap on the command side after a beat.
    task automatic command_gap();
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering commands and waits until every result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (results_seen != cmds_sent)
            @(posedge clk);
    endtask

    // Writes the capacity limit; only ever called with the block idle.
    task automatic write_limit(logic [8:0] lim);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // One random command. Most beats are well formed for the list as it now
    // stands (a position within it); the rest carry any position at all.
    // grow sets the share of appends and inserts against deletes and reads.
    task automatic random_command(int grow);
        op_t        op;
        logic [8:0] pos;
        int         held;
        held = list_len;
        if ($urandom_range(0, 99) < grow)
            op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
        else
            op = ($urandom_range(0, 3) != 0) ? OP_DELETE : OP_READ;
        if ($urandom_range(0, 99) < 12 || (held == 0 && op != OP_INSERT))
            pos = 9'($urandom_range(0, 511));
        else if (op == OP_INSERT)
            pos = 9'($urandom_range(0, held));
        else
            pos = 9'($urandom_range(0, held - 1));
        drive_beat(op, pos, $urandom, 1'b0, '0);
        command_gap();
    endtask

    initial
    begin : stimulus
        int ph;
        int n;
        // Known values on every input from time zero.
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_APPEND;
        position  <= '0;
        value     <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        pin_valid <= 1'b0;
        pin_exp   <= '0;
        calm         = 1'b0;
        hold_req     = 0;
        hold_done    = 0;
        cmds_sent    = 0;
        results_seen = 0;
        fail_count   = 0;
        // Predictor comes out of reset like the block: empty, limit 256.
        list_len  = 0;
        cap_limit = 9'd256;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script.
        foreach (dir_script[i])
        begin
            if (dir_script[i].kind == ROW_CFG)
                write_limit(dir_script[i].val[8:0]);
            else
            begin
                drive_beat(dir_script[i].op, dir_script[i].pos, dir_script[i].val,
                           dir_script[i].pinned,
                           '{st: dir_script[i].st, dat: dir_script[i].dat,
                             cnt: dir_script[i].cnt});
                command_gap();
            end
        end
        pin_valid <= 1'b0;

        // Random phases, each under its own limit.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_limit(9'(PH_LIMIT[ph]));
            for (n = 0; n < PH_ITEMS[ph]; n++)
            begin
                // Stretches with no idling on either side now and then.
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (ph == PRESSURE_PHASE && n == 0)
                begin
                    // Hold the result side off for a long stretch while beats
                    // keep coming back to back, so that the block fills up
                    // and stalls its command input.
                    calm = 1'b1;
                    hold_req <= hold_req + 1;
                end
                if (ph == PRESSURE_PHASE && n == 40)
                    calm = 1'b0;
                if (ph == PRESSURE_PHASE && n == PH_ITEMS[ph] / 2)
                    wait_for_results();
                random_command(PH_GROW[ph]);
            end
        end

        // Let everything come back, then give the block time to show any
        // result beat it should not have produced.
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        if (fail_count == 0)
            $display("** indexed_list_insert_delete: PASSED **");
        else
            $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

    // Backstop: several times the slowest correct run.
    initial
    begin
        #20000000;
        $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

endmodule

// ===== indexed_list_insert_delete.f =====
rtl/core/ilid_pkg.sv
rtl/core/ilid_store.sv
rtl/core/indexed_list_insert_delete.sv
dv/tb_top.sv
